/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock, off while reset is low.
`define PIDQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pidq check failed");

`endif

/* rtl/pidq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq_pkg
// Types, codes and defaults shared by the positional insert/delete queue.
// ----------------------------------------------------------------------------
package pidq_pkg;

  localparam int unsigned DEPTH_DEFAULT       = 64;
  localparam int unsigned ENTRY_WIDTH_DEFAULT = 32;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // What a cell does with its word in the coming cycle.
  typedef enum logic [1:0] {
    ACT_HOLD       = 2'd0,
    ACT_LOAD       = 2'd1,
    ACT_FROM_LOWER = 2'd2,
    ACT_FROM_UPPER = 2'd3
  } cell_act_e;

  typedef struct packed {
    cell_act_e act;
    logic      take;
  } cell_ctrl_t;

  typedef struct packed {
    mode_e               mode;
    logic [POS_W-1:0]    position;
    logic [WORD_W-1:0]   entry_value;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]   removed_value;
    logic [WORD_W-1:0]   front_value;
    logic [COUNT_W-1:0]  entry_count;
    status_e             status;
  } rsp_t;

endpackage

/* rtl/pidq_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface pidq_req_if;
  logic          valid;
  logic          ready;
  pidq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pidq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface pidq_rsp_if;
  logic          valid;
  logic          ready;
  pidq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/positional_insert_delete_queue.sv */
`timescale 1ns / 1ps
// Results: a result item is registered and offered in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; all shifting cells move in that cycle.
// A stalled result holds the request side only until that result is taken.
// Reset: asynchronous, active low; clears the entry count and the result valid.
// Cell words are not cleared; a slot is read only after it has been written.
// ----------------------------------------------------------------------------
// positional_insert_delete_queue
// Ordered queue with append, remove-front, insert and delete at a position.
// ----------------------------------------------------------------------------
module positional_insert_delete_queue #(
  parameter int unsigned DEPTH       = pidq_pkg::DEPTH_DEFAULT,
  parameter int unsigned ENTRY_WIDTH = pidq_pkg::ENTRY_WIDTH_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pidq_req_if.sink     req_i,
  pidq_rsp_if.source   rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > pidq_pkg::POS_W) ? CW : pidq_pkg::POS_W) + 1;

  logic [CW-1:0]          count_q, count_d;
  logic                   rsp_valid_q;
  pidq_pkg::rsp_t         rsp_q;

  logic                   accept;
  logic                   do_ins, do_del;
  logic [AW-1:0]          idx;
  pidq_pkg::status_e      status;
  logic [PW-1:0]          pos_ext, cnt_ext;
  logic                   ins_in_range, del_in_range;
  logic                   full, empty;
  logic [ENTRY_WIDTH-1:0] load_word;
  logic [ENTRY_WIDTH-1:0] removed;

  pidq_pkg::cell_ctrl_t   ctrl  [DEPTH];
  logic [ENTRY_WIDTH-1:0] value [DEPTH];
  logic [ENTRY_WIDTH-1:0] value_d [DEPTH];
  logic [ENTRY_WIDTH-1:0] tap   [DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);
  assign pos_ext = PW'(req_i.data.position);
  assign cnt_ext = PW'(count_q);
  assign ins_in_range = (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1));
  assign del_in_range = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign load_word    = ENTRY_WIDTH'(req_i.data.entry_value);

  // Decode the request into one insert or delete at a slot index, or into an error status.
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    status = pidq_pkg::ST_OK;
    case (req_i.data.mode)
      pidq_pkg::MODE_APPEND: begin
        if (full) status = pidq_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          idx    = AW'(count_q);
        end
      end
      pidq_pkg::MODE_REMOVE: begin
        if (empty) status = pidq_pkg::ST_EMPTY;
        else do_del = 1'b1;
      end
      pidq_pkg::MODE_INSERT: begin
        if (full) status = pidq_pkg::ST_FULL;
        else if (!ins_in_range) status = pidq_pkg::ST_RANGE;
        else begin
          do_ins = 1'b1;
          idx    = AW'(pos_ext - PW'(1));
        end
      end
      default: begin
        if (empty) status = pidq_pkg::ST_EMPTY;
        else if (!del_in_range) status = pidq_pkg::ST_RANGE;
        else begin
          do_del = 1'b1;
          idx    = AW'(pos_ext - PW'(1));
        end
      end
    endcase
  end

  // Per-slot action: shift up behind an insert point, down from a delete point.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].act  = pidq_pkg::ACT_HOLD;
      ctrl[i].take = do_del && (AW'(i) == idx);
      if (accept && do_ins) begin
        if (AW'(i) == idx)     ctrl[i].act = pidq_pkg::ACT_LOAD;
        else if (AW'(i) > idx) ctrl[i].act = pidq_pkg::ACT_FROM_LOWER;
      end else if (accept && do_del) begin
        if (AW'(i) >= idx) ctrl[i].act = pidq_pkg::ACT_FROM_UPPER;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pidq_cell #(
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[g]),
      .load_i    (load_word),
      .lower_i   ((g == 0) ? '0 : value[(g == 0) ? 0 : g - 1]),
      .upper_i   ((g == DEPTH - 1) ? '0 : value[(g == DEPTH - 1) ? g : g + 1]),
      .value_o   (value[g]),
      .value_d_o (value_d[g]),
      .tap_o     (tap[g])
    );
  end

  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | tap[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins)      count_d = count_q + CW'(1);
    else if (do_del) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q.removed_value <= pidq_pkg::WORD_W'(removed);
      rsp_q.front_value   <= (count_d == '0) ? '0 : pidq_pkg::WORD_W'(value_d[0]);
      rsp_q.entry_count   <= pidq_pkg::COUNT_W'(count_d);
      rsp_q.status        <= status;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

/* rtl/pidq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq_cell
// One queue slot: holds, loads, or takes the word of a neighbor each cycle.
// ----------------------------------------------------------------------------
module pidq_cell #(
  parameter int unsigned ENTRY_WIDTH = pidq_pkg::ENTRY_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  pidq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [ENTRY_WIDTH-1:0] load_i,
  input  logic [ENTRY_WIDTH-1:0] lower_i,
  input  logic [ENTRY_WIDTH-1:0] upper_i,
  output logic [ENTRY_WIDTH-1:0] value_o,
  output logic [ENTRY_WIDTH-1:0] value_d_o,
  output logic [ENTRY_WIDTH-1:0] tap_o
);

  logic [ENTRY_WIDTH-1:0] value_q;
  logic [ENTRY_WIDTH-1:0] value_d;

  always_comb begin
    case (ctrl_i.act)
      pidq_pkg::ACT_LOAD:       value_d = load_i;
      pidq_pkg::ACT_FROM_LOWER: value_d = lower_i;
      pidq_pkg::ACT_FROM_UPPER: value_d = upper_i;
      default:                  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign value_d_o = value_d;
  // Put the word on the removal bus only when this slot is the one deleted.
  assign tap_o     = ctrl_i.take ? value_q : '0;

endmodule

/* rtl/pidq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidq_checker
// Port-level checks on the queue's request and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidq_checker #(
  parameter int unsigned DEPTH = pidq_pkg::DEPTH_DEFAULT
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               req_valid_i,
  input logic                               req_ready_i,
  input logic                               rsp_valid_i,
  input logic                               rsp_ready_i,
  input logic [pidq_pkg::WORD_W-1:0]        removed_value_i,
  input logic [pidq_pkg::WORD_W-1:0]        front_value_i,
  input logic [pidq_pkg::COUNT_W-1:0]       entry_count_i,
  input pidq_pkg::status_e                  status_i
);

  // Every accepted request shows its result on the next cycle.
  `PIDQ_ASSERT(a_rsp_follows_req, clk_i, rst_ni, (req_valid_i && req_ready_i) |=> rsp_valid_i)

  // Hold a stalled result.
  `PIDQ_ASSERT(a_rsp_hold, clk_i, rst_ni, (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(removed_value_i) && $stable(entry_count_i)))

  // A full report only comes with the queue at capacity.
  `PIDQ_ASSERT(a_full_count, clk_i, rst_ni, (rsp_valid_i && status_i == pidq_pkg::ST_FULL) |-> (entry_count_i == pidq_pkg::COUNT_W'(DEPTH)))

  // An empty queue shows a zero front word.
  `PIDQ_ASSERT(a_empty_front, clk_i, rst_ni, (rsp_valid_i && entry_count_i == '0) |-> (front_value_i == '0))

  // A failed request removes nothing.
  `PIDQ_ASSERT(a_fail_no_removal, clk_i, rst_ni, (rsp_valid_i && status_i != pidq_pkg::ST_OK) |-> (removed_value_i == '0))

endmodule

bind positional_insert_delete_queue pidq_checker #(
  .DEPTH (DEPTH)
) u_pidq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .removed_value_i (rsp_o.data.removed_value),
  .front_value_i   (rsp_o.data.front_value),
  .entry_count_i   (rsp_o.data.entry_count),
  .status_i        (rsp_o.data.status)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional insert/delete queue. A short
// directed list covers the empty and out-of-range corners, and fill/drain
// sweeps with random content follow. A shadow queue predicts each result
// the list does not fix, and the bench compares each result field by
// field; in some phases the sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DEPTH       = pidq_pkg::DEPTH_DEFAULT;
  localparam int unsigned ENTRY_WIDTH = pidq_pkg::ENTRY_WIDTH_DEFAULT;
  localparam int          PHASE_ITEMS = 500;
  localparam int          HOLD_OFF    = 300;
  localparam int          SETTLE      = 8;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          MAX_REPORTS = 20;

  typedef struct {
    pidq_pkg::req_t r;
    bit             typed;
    pidq_pkg::rsp_t want;
  } stim_row_t;

  typedef struct {
    bit             typed;
    pidq_pkg::rsp_t want;
  } fixed_want_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pidq_req_if req_if ();
  pidq_rsp_if rsp_if ();

  positional_insert_delete_queue #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [pidq_pkg::WORD_W-1:0] held_entries[$];
  pidq_pkg::rsp_t              pending_results[$];
  fixed_want_t                 fixed_wants[$];
  stim_row_t                   directed_rows[$];

  int  idle_pct    = 0;
  int  stall_pct   = 0;
  int  hold_cycles = 0;
  int  n_sent      = 0;
  int  n_done      = 0;
  int  errors      = 0;
  int  peak_count  = 0;
  int  cycle_count = 0;
  int  status_seen[4];
  bit  filling     = 1'b1;

  // Shadow of the queue: apply one request and return the result it gives.
  function automatic pidq_pkg::rsp_t apply_request(pidq_pkg::req_t r);
    pidq_pkg::rsp_t o;
    int             n;
    int             p;
    n = held_entries.size();
    p = r.position;
    o = '0;
    o.status = pidq_pkg::ST_OK;
    case (r.mode)
      pidq_pkg::MODE_APPEND: begin
        if (n >= DEPTH) o.status = pidq_pkg::ST_FULL;
        else held_entries.push_back(r.entry_value);
      end
      pidq_pkg::MODE_REMOVE: begin
        if (n == 0) o.status = pidq_pkg::ST_EMPTY;
        else o.removed_value = held_entries.pop_front();
      end
      pidq_pkg::MODE_INSERT: begin
        if (n >= DEPTH) o.status = pidq_pkg::ST_FULL;
        else if (p < 1 || p > n + 1) o.status = pidq_pkg::ST_RANGE;
        else held_entries.insert(p - 1, r.entry_value);
      end
      default: begin
        if (n == 0) o.status = pidq_pkg::ST_EMPTY;
        else if (p < 1 || p > n) o.status = pidq_pkg::ST_RANGE;
        else begin
          o.removed_value = held_entries[p - 1];
          held_entries.delete(p - 1);
        end
      end
    endcase
    o.front_value = (held_entries.size() != 0) ? held_entries[0] : '0;
    o.entry_count = pidq_pkg::COUNT_W'(held_entries.size());
    return o;
  endfunction

  function automatic logic [pidq_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Sweep between empty and full; linger at the ends so both corners get hit.
  function automatic pidq_pkg::req_t random_request();
    pidq_pkg::req_t r;
    int             n;
    bit             grow;
    n = held_entries.size();
    if (filling && n >= DEPTH && $urandom_range(9) == 0) filling = 1'b0;
    else if (!filling && n == 0 && $urandom_range(3) == 0) filling = 1'b1;
    r.entry_value = random_word();
    if ($urandom_range(9) == 0) begin
      r.mode     = pidq_pkg::mode_e'($urandom_range(3));
      r.position = pidq_pkg::POS_W'($urandom_range(127));
      return r;
    end
    grow = (($urandom_range(99) < 75) == filling);
    if (grow) begin
      r.mode     = $urandom_range(1) ? pidq_pkg::MODE_APPEND : pidq_pkg::MODE_INSERT;
      r.position = pidq_pkg::POS_W'($urandom_range(n + 1, 1));
    end else begin
      r.mode     = $urandom_range(1) ? pidq_pkg::MODE_REMOVE : pidq_pkg::MODE_DELETE;
      r.position = (n != 0) ? pidq_pkg::POS_W'($urandom_range(n, 1))
                            : pidq_pkg::POS_W'($urandom_range(127));
    end
    return r;
  endfunction

  function automatic void add_row(pidq_pkg::mode_e m, int pos,
                                  logic [pidq_pkg::WORD_W-1:0] val, bit typed,
                                  logic [pidq_pkg::WORD_W-1:0] rm,
                                  logic [pidq_pkg::WORD_W-1:0] fr,
                                  int cnt, pidq_pkg::status_e st);
    stim_row_t row;
    row.r.mode                = m;
    row.r.position            = pidq_pkg::POS_W'(pos);
    row.r.entry_value         = val;
    row.typed                 = typed;
    row.want.removed_value    = rm;
    row.want.front_value      = fr;
    row.want.entry_count      = pidq_pkg::COUNT_W'(cnt);
    row.want.status           = st;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string field, logic [pidq_pkg::WORD_W-1:0] want,
                                 logic [pidq_pkg::WORD_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  task automatic check_result(pidq_pkg::rsp_t got);
    pidq_pkg::rsp_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.removed_value !== want.removed_value)
      report_mismatch("removed_value", want.removed_value, got.removed_value);
    if (got.front_value !== want.front_value)
      report_mismatch("front_value", want.front_value, got.front_value);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", pidq_pkg::WORD_W'(want.entry_count),
                      pidq_pkg::WORD_W'(got.entry_count));
    if (got.status !== want.status)
      report_mismatch("status", pidq_pkg::WORD_W'(want.status),
                      pidq_pkg::WORD_W'(got.status));
  endtask

  // Predict at request acceptance, check at result acceptance.
  always @(posedge clk_i) begin : scoreboard
    pidq_pkg::rsp_t predicted;
    fixed_want_t    fw;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        predicted = apply_request(req_if.data);
        fw = fixed_wants.pop_front();
        pending_results.push_back(fw.typed ? fw.want : predicted);
        if (held_entries.size() > peak_count) peak_count = held_entries.size();
      end
      if (rsp_if.valid && rsp_if.ready) begin
        check_result(rsp_if.data);
        status_seen[rsp_if.data.status]++;
        n_done++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : result_sink
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(pidq_pkg::req_t r, bit typed, pidq_pkg::rsp_t want);
    fixed_want_t fw;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    fw.typed = typed;
    fw.want  = want;
    fixed_wants.push_back(fw);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    wait (n_done >= n_sent);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int idle_by_phase[4];
    int stall_by_phase[4];
    idle_by_phase  = '{0, 46, 0, 15};
    stall_by_phase = '{0, 0, 46, 15};

    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;

    add_row(pidq_pkg::MODE_REMOVE, 0, 32'h0, 1, 32'h0, 32'h0, 0, pidq_pkg::ST_EMPTY);
    add_row(pidq_pkg::MODE_DELETE, 1, 32'h0, 1, 32'h0, 32'h0, 0, pidq_pkg::ST_EMPTY);
    add_row(pidq_pkg::MODE_DELETE, 127, 32'h0, 1, 32'h0, 32'h0, 0, pidq_pkg::ST_EMPTY);
    add_row(pidq_pkg::MODE_INSERT, 0, 32'h12345678, 1, 32'h0, 32'h0, 0, pidq_pkg::ST_RANGE);
    add_row(pidq_pkg::MODE_INSERT, 2, 32'h12345678, 1, 32'h0, 32'h0, 0, pidq_pkg::ST_RANGE);
    add_row(pidq_pkg::MODE_INSERT, 1, 32'hFFFFFFFF, 1, 32'h0, 32'hFFFFFFFF, 1,
            pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_APPEND, 0, 32'h00000000, 1, 32'h0, 32'hFFFFFFFF, 2,
            pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_INSERT, 3, 32'h5A5A5A5A, 0, 32'h0, 32'h0, 0, pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_INSERT, 1, 32'h00000001, 1, 32'h0, 32'h00000001, 4,
            pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_INSERT, 3, 32'hA5A5A5A5, 0, 32'h0, 32'h0, 0, pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_DELETE, 0, 32'h0, 1, 32'h0, 32'h00000001, 5, pidq_pkg::ST_RANGE);
    add_row(pidq_pkg::MODE_DELETE, 6, 32'h0, 1, 32'h0, 32'h00000001, 5, pidq_pkg::ST_RANGE);
    add_row(pidq_pkg::MODE_INSERT, 127, 32'hDEADBEEF, 1, 32'h0, 32'h00000001, 5,
            pidq_pkg::ST_RANGE);
    add_row(pidq_pkg::MODE_DELETE, 3, 32'h0, 0, 32'h0, 32'h0, 0, pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_DELETE, 4, 32'h0, 0, 32'h0, 32'h0, 0, pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_DELETE, 1, 32'h0, 0, 32'h0, 32'h0, 0, pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_REMOVE, 0, 32'h0, 0, 32'h0, 32'h0, 0, pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_REMOVE, 64, 32'h0, 1, 32'h0, 32'h0, 0, pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_APPEND, 127, 32'hAAAAAAAA, 1, 32'h0, 32'hAAAAAAAA, 1,
            pidq_pkg::ST_OK);
    add_row(pidq_pkg::MODE_DELETE, 1, 32'h0, 1, 32'hAAAAAAAA, 32'h0, 0, pidq_pkg::ST_OK);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      // Block the result side while requests keep coming, to back up the input.
      if (ph == 0) hold_cycles = HOLD_OFF;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_item(random_request(), 1'b0, '0);
      drain_results();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("Covered %0d requests: ok %0d, empty %0d, full %0d, out of range %0d.",
             n_sent, status_seen[pidq_pkg::ST_OK], status_seen[pidq_pkg::ST_EMPTY],
             status_seen[pidq_pkg::ST_FULL], status_seen[pidq_pkg::ST_RANGE]);
    $display("Peak occupancy %0d of %0d; %0d mismatches.", peak_count, DEPTH, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pidq_pkg.sv
rtl/pidq_req_if.sv
rtl/pidq_rsp_if.sv
rtl/pidq_cell.sv
rtl/positional_insert_delete_queue.sv
rtl/pidq_checker.sv
tb/tb_top.sv
